// ----- rtl/sfrq_pkg.sv -----
// Shared types and constants of the sorted or arrival-order request queue.
// Used by the cell, the top level and the checker; depends on nothing.
package sfrq_pkg;

	localparam int DEPTH  = 16;
	localparam int KEY_W  = 32;
	localparam int TAG_W  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FILL_W = 5;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	// Command broadcast to every cell in the cycle a word is accepted.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             sorted;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} cell_cmd_t;

endpackage

// ----- rtl/sfrq_cell.sv -----
// One slot of the queue: holds a key and a tag and trades them with its neighbours.
// Depends on sfrq_pkg for the command struct and field widths.
module sfrq_cell (
	input  logic                    clk,
	input  sfrq_pkg::cell_cmd_t     cmd,
	input  logic                    occupied,
	input  logic                    prev_hit,
	input  logic [sfrq_pkg::KEY_W-1:0] left_key,
	input  logic [sfrq_pkg::TAG_W-1:0] left_tag,
	input  logic [sfrq_pkg::KEY_W-1:0] right_key,
	input  logic [sfrq_pkg::TAG_W-1:0] right_tag,
	output logic                    hit_out,
	output logic [sfrq_pkg::KEY_W-1:0] key_q,
	output logic [sfrq_pkg::TAG_W-1:0] tag_q,
	output logic [sfrq_pkg::KEY_W-1:0] key_nxt,
	output logic [sfrq_pkg::TAG_W-1:0] tag_nxt
);
	import sfrq_pkg::*;

	logic hit;

	// A new entry goes before the first slot that is free or, in sorted mode, holds a strictly greater key.
	assign hit     = !occupied || (cmd.sorted && (key_q > cmd.key));
	assign hit_out = prev_hit || hit;

	always_comb begin
		key_nxt = key_q;
		tag_nxt = tag_q;
		if (cmd.rem) begin
			key_nxt = right_key;
			tag_nxt = right_tag;
		end else if (cmd.ins && prev_hit) begin
			key_nxt = left_key;
			tag_nxt = left_tag;
		end else if (cmd.ins && hit) begin
			key_nxt = cmd.key;
			tag_nxt = cmd.tag;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_nxt;
		tag_q <= tag_nxt;
	end

endmodule

// ----- rtl/sorted_or_fifo_request_queue.sv -----
// Top level of the request queue: a chain of slot cells, fill count and result register.
// Depends on sfrq_pkg and sfrq_cell.
//
// Each input word either inserts a request (key and tag) or removes the head.
// With the mode bit clear an insert appends; with it set an insert goes
// before the first held key that is strictly greater, so equal keys keep
// their arrival order. Every slot compares its key with the new one at once and
// shifts left or right in the same cycle, so one word is taken per cycle when
// in_ready is high. Each word yields one result word, registered and presented
// on the cycle after acceptance, that gives the removed entry, a status, the
// fill count and the head after the operation. An insert into a full queue is
// dropped with status full; a remove on an empty queue returns status empty.
// While a result waits for out_ready the next word is still taken if the
// result is taken in the same cycle; otherwise in_ready is low. Reset empties
// the queue, drops any pending result word and selects arrival order. The user
// must write the configuration register via cfg_we only while idle (not enforced).
module sorted_or_fifo_request_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [sfrq_pkg::KEY_W-1:0]  req_key,
	input  logic [sfrq_pkg::TAG_W-1:0]  req_tag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        removed_valid,
	output logic [sfrq_pkg::KEY_W-1:0]  removed_key,
	output logic [sfrq_pkg::TAG_W-1:0]  removed_tag,
	output logic [1:0]                  status,
	output logic [sfrq_pkg::FILL_W-1:0] fill_count,
	output logic                        head_valid,
	output logic [sfrq_pkg::KEY_W-1:0]  head_key,
	output logic [sfrq_pkg::TAG_W-1:0]  head_tag
);
	import sfrq_pkg::*;

	logic             mode_q;
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] held_nxt;
	logic             accept;
	logic             is_full;
	logic             is_empty;
	cell_cmd_t        cmd;
	status_t          st_nxt;

	logic [KEY_W-1:0] cell_key   [DEPTH];
	logic [TAG_W-1:0] cell_tag   [DEPTH];
	logic [KEY_W-1:0] cell_key_n [DEPTH];
	logic [TAG_W-1:0] cell_tag_n [DEPTH];
	logic [DEPTH:0]   hit_chain;

	logic             out_valid_q;
	logic             rvalid_q;
	logic [KEY_W-1:0] rkey_q;
	logic [TAG_W-1:0] rtag_q;
	status_t          st_q;
	logic [CNT_W-1:0] fill_q;
	logic             hvalid_q;
	logic [KEY_W-1:0] hkey_q;
	logic [TAG_W-1:0] htag_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_full  = (held_q == CNT_W'(DEPTH));
	assign is_empty = (held_q == '0);

	assign cmd.ins    = accept && (kind == KIND_INSERT) && !is_full;
	assign cmd.rem    = accept && (kind == KIND_REMOVE) && !is_empty;
	assign cmd.sorted = mode_q;
	assign cmd.key    = req_key;
	assign cmd.tag    = req_tag;

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] lk;
		logic [TAG_W-1:0] lt;
		logic [KEY_W-1:0] rk;
		logic [TAG_W-1:0] rt;

		if (i == 0) begin : g_first
			assign lk = req_key;
			assign lt = req_tag;
		end else begin : g_mid
			assign lk = cell_key[i-1];
			assign lt = cell_tag[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rk = cell_key[i];
			assign rt = cell_tag[i];
		end else begin : g_inner
			assign rk = cell_key[i+1];
			assign rt = cell_tag[i+1];
		end

		sfrq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (CNT_W'(i) < held_q),
			.prev_hit  (hit_chain[i]),
			.left_key  (lk),
			.left_tag  (lt),
			.right_key (rk),
			.right_tag (rt),
			.hit_out   (hit_chain[i+1]),
			.key_q     (cell_key[i]),
			.tag_q     (cell_tag[i]),
			.key_nxt   (cell_key_n[i]),
			.tag_nxt   (cell_tag_n[i])
		);
	end

	always_comb begin
		held_nxt = held_q;
		st_nxt   = ST_DONE;
		if (cmd.ins) begin
			held_nxt = held_q + CNT_W'(1);
		end else if (cmd.rem) begin
			held_nxt = held_q - CNT_W'(1);
		end
		if (kind == KIND_INSERT && is_full) begin
			st_nxt = ST_FULL;
		end else if (kind == KIND_REMOVE && is_empty) begin
			st_nxt = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			held_q <= held_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rvalid_q <= cmd.rem;
			rkey_q   <= cmd.rem ? cell_key[0] : '0;
			rtag_q   <= cmd.rem ? cell_tag[0] : '0;
			st_q     <= st_nxt;
			fill_q   <= held_nxt;
			hvalid_q <= (held_nxt != '0);
			hkey_q   <= (held_nxt != '0) ? cell_key_n[0] : '0;
			htag_q   <= (held_nxt != '0) ? cell_tag_n[0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_valid = rvalid_q;
	assign removed_key   = rkey_q;
	assign removed_tag   = rtag_q;
	assign status        = st_q;
	assign fill_count    = FILL_W'(fill_q);
	assign head_valid    = hvalid_q;
	assign head_key      = hkey_q;
	assign head_tag      = htag_q;

endmodule

// ----- rtl/sfrq_checker.sv -----
// Port-level checks of the request queue's result words, bound to the top level.
// Depends on sfrq_pkg and sorted_or_fifo_request_queue.
module sfrq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        removed_valid,
	input logic [1:0]                  status,
	input logic [sfrq_pkg::FILL_W-1:0] fill_count,
	input logic                        head_valid
);
	import sfrq_pkg::*;

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (fill_count == FILL_W'(DEPTH)))
		else $error("A dropped insert reports a queue that is not full.");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (fill_count == '0 && !head_valid))
		else $error("A remove on empty reports held entries.");

	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head_valid == (fill_count != '0)))
		else $error("The head flag disagrees with the fill count.");

	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && removed_valid) |-> (status == ST_DONE))
		else $error("A removed word carries an error status.");

endmodule

bind sorted_or_fifo_request_queue sfrq_checker u_sfrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.removed_valid (removed_valid),
	.status        (status),
	.fill_count    (fill_count),
	.head_valid    (head_valid)
);
